FILE: hw/rtl/chrt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the consistent hash ring table.
// No dependencies; imported by chrt_seq, consistent_hash_ring_table, chrt_ring_checker and the testbench.
package chrt_pkg;

	localparam int POINT_W = 64;
	localparam int SITE_W  = 64;
	localparam int ENTRY_W = POINT_W + SITE_W;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_DEL    = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_NONE   = 2'd3
	} chrt_op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} chrt_status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SRCH,
		S_CMP,
		S_SHUP,
		S_INS,
		S_DEL_RD,
		S_DEL_CAP,
		S_DEL_SH,
		S_DEL_FIN,
		S_LK_RD,
		S_LK_CAP,
		S_RESP
	} chrt_state_t;

	typedef struct packed {
		chrt_status_t       status;
		logic [7:0]         index;
		logic [POINT_W-1:0] point;
		logic [SITE_W-1:0]  site;
		logic [8:0]         total;
	} chrt_result_t;

endpackage

FILE: hw/rtl/chrt_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module chrt_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/chrt_seq.sv
`timescale 1ns / 1ps
// Operation sequencer: binary search, shift-insert and shift-delete over the entry RAM.
// Depends on chrt_pkg; drives one chrt_ram instance.
module chrt_seq #(
	parameter int CAPACITY = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  op,
	input  logic [63:0]                 key_point,
	input  logic [63:0]                 site_ident,
	input  logic [7:0]                  entry_index,
	output logic                        mem_we,
	output logic [$clog2(CAPACITY)-1:0] mem_waddr,
	output logic [chrt_pkg::ENTRY_W-1:0] mem_wdata,
	output logic [$clog2(CAPACITY)-1:0] mem_raddr,
	input  logic [chrt_pkg::ENTRY_W-1:0] mem_rdata,
	output logic                        res_valid,
	input  logic                        res_ready,
	output chrt_pkg::chrt_result_t      res
);

	import chrt_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	chrt_state_t state_q, state_d;
	chrt_op_t    op_q;
	logic [POINT_W-1:0] key_q;
	logic [SITE_W-1:0]  site_q;

	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, cur_q, cur_d;
	logic [CW-1:0] cur_dec, rd_addr;
	logic          wb_vld_s1, wb_vld_d;
	logic [IW-1:0] wb_addr_s1, wb_addr_d;
	logic          ins_we;

	chrt_status_t       res_status_q, res_status_d;
	logic [CW-1:0]      res_pos_q, res_pos_d;
	logic [POINT_W-1:0] res_point_q, res_point_d;
	logic [SITE_W-1:0]  res_site_q, res_site_d;

	logic [POINT_W-1:0] rd_point;
	logic [SITE_W-1:0]  rd_site;
	logic [CW+7:0]      idx_ext, cnt_ext, pos_ext;
	logic [CW+8:0]      tot_ext;
	logic               pt_lt;
	chrt_op_t           in_op;

	assign rd_point = mem_rdata[ENTRY_W-1 -: POINT_W];
	assign rd_site  = mem_rdata[SITE_W-1:0];
	assign idx_ext  = {{CW{1'b0}}, entry_index};
	assign cnt_ext  = {8'd0, count_q};
	assign cur_dec  = cur_q - 1'b1;
	assign in_op    = chrt_op_t'(op);
	// add searches for the first greater point, lookup for the first at or above
	assign pt_lt    = (op_q == OP_ADD) ? (rd_point <= key_q) : (rd_point < key_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			wb_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			wb_vld_s1 <= wb_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			op_q   <= in_op;
			key_q  <= key_point;
			site_q <= site_ident;
		end
		lo_q         <= lo_d;
		hi_q         <= hi_d;
		mid_q        <= mid_d;
		cur_q        <= cur_d;
		wb_addr_s1   <= wb_addr_d;
		res_status_q <= res_status_d;
		res_pos_q    <= res_pos_d;
		res_point_q  <= res_point_d;
		res_site_q   <= res_site_d;
	end

	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		lo_d         = lo_q;
		hi_d         = hi_q;
		mid_d        = mid_q;
		cur_d        = cur_q;
		wb_vld_d     = 1'b0;
		wb_addr_d    = wb_addr_s1;
		res_status_d = res_status_q;
		res_pos_d    = res_pos_q;
		res_point_d  = res_point_q;
		res_site_d   = res_site_q;
		rd_addr      = cur_q;
		ins_we       = 1'b0;
		in_ready     = 1'b0;
		res_valid    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					lo_d         = '0;
					hi_d         = count_q;
					res_status_d = ST_OK;
					res_pos_d    = '0;
					res_point_d  = '0;
					res_site_d   = '0;
					unique case (in_op)
						OP_ADD: begin
							if (count_q == CAP_C) begin
								res_status_d = ST_FULL;
								state_d      = S_RESP;
							end else begin
								state_d = S_SRCH;
							end
						end
						OP_DEL: begin
							if (idx_ext >= cnt_ext) begin
								res_status_d = ST_RANGE;
								state_d      = S_RESP;
							end else begin
								cur_d     = idx_ext[CW-1:0];
								res_pos_d = idx_ext[CW-1:0];
								state_d   = S_DEL_RD;
							end
						end
						OP_LOOKUP: begin
							if (count_q == '0) begin
								res_status_d = ST_EMPTY;
								state_d      = S_RESP;
							end else begin
								state_d = S_SRCH;
							end
						end
						OP_NONE: begin
							state_d = S_RESP;
						end
					endcase
				end
			end
			S_SRCH: begin
				if (lo_q < hi_q) begin
					mid_d   = lo_q + ((hi_q - lo_q) >> 1);
					rd_addr = mid_d;
					state_d = S_CMP;
				end else if (op_q == OP_ADD) begin
					cur_d   = count_q;
					state_d = S_SHUP;
				end else begin
					state_d = S_LK_RD;
				end
			end
			S_CMP: begin
				if (pt_lt) begin
					lo_d = mid_q + 1'b1;
				end else begin
					hi_d = mid_q;
				end
				state_d = S_SRCH;
			end
			S_SHUP: begin
				// read slot i-1, write it to slot i in the next cycle
				if (cur_q > lo_q) begin
					rd_addr   = cur_dec;
					wb_vld_d  = 1'b1;
					wb_addr_d = cur_q[IW-1:0];
					cur_d     = cur_dec;
				end else begin
					state_d = S_INS;
				end
			end
			S_INS: begin
				// wait for the last moved entry to land before the new one goes in
				if (!wb_vld_s1) begin
					ins_we      = 1'b1;
					count_d     = count_q + 1'b1;
					res_pos_d   = lo_q;
					res_point_d = key_q;
					res_site_d  = site_q;
					state_d     = S_RESP;
				end
			end
			S_DEL_RD: begin
				rd_addr = cur_q;
				cur_d   = cur_q + 1'b1;
				state_d = S_DEL_CAP;
			end
			S_DEL_CAP: begin
				res_point_d = rd_point;
				res_site_d  = rd_site;
				state_d     = S_DEL_SH;
			end
			S_DEL_SH: begin
				if (cur_q < count_q) begin
					rd_addr   = cur_q;
					wb_vld_d  = 1'b1;
					wb_addr_d = cur_dec[IW-1:0];
					cur_d     = cur_q + 1'b1;
				end else begin
					state_d = S_DEL_FIN;
				end
			end
			S_DEL_FIN: begin
				if (!wb_vld_s1) begin
					count_d = count_q - 1'b1;
					state_d = S_RESP;
				end
			end
			S_LK_RD: begin
				// no point at or above the key: wrap to the first entry
				cur_d     = (lo_q == count_q) ? '0 : lo_q;
				rd_addr   = cur_d;
				res_pos_d = cur_d;
				state_d   = S_LK_CAP;
			end
			S_LK_CAP: begin
				res_point_d = rd_point;
				res_site_d  = rd_site;
				state_d     = S_RESP;
			end
			S_RESP: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
		endcase
	end

	assign mem_raddr = rd_addr[IW-1:0];
	assign mem_we    = wb_vld_s1 | ins_we;
	assign mem_waddr = wb_vld_s1 ? wb_addr_s1 : lo_q[IW-1:0];
	assign mem_wdata = wb_vld_s1 ? mem_rdata : {key_q, site_q};

	assign pos_ext = {8'd0, res_pos_q};
	assign tot_ext = {9'd0, count_q};

	always_comb begin
		res.status = res_status_q;
		res.index  = pos_ext[7:0];
		res.point  = res_point_q;
		res.site   = res_site_q;
		res.total  = tot_ext[8:0];
	end

endmodule

FILE: hw/rtl/consistent_hash_ring_table.sv
`timescale 1ns / 1ps
// Consistent hash ring table top level: sequencer, entry RAM and output register.
// Depends on chrt_pkg, chrt_ram and chrt_seq.
//
//   channel  handshake           payload
//   in       in_valid/in_ready    op, key_point, site_ident, entry_index
//   out      out_valid/out_ready  status, found_index, found_point, found_site, entry_total
//
// One item at a time. A lookup is a binary search over the n stored entries, an add is
// a binary search followed by moving the entries above the new one, a delete moves the
// entries above the removed one; the entry RAM has a single read port and a single write port.
// Reset empties the table at once; entry RAM contents are not cleared.
// A result waits in the output register while the next item is taken.
module consistent_hash_ring_table #(
	parameter int CAPACITY = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [63:0] key_point,
	input  logic [63:0] site_ident,
	input  logic [7:0]  entry_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [7:0]  found_index,
	output logic [63:0] found_point,
	output logic [63:0] found_site,
	output logic [8:0]  entry_total
);

	import chrt_pkg::*;

	localparam int IW = $clog2(CAPACITY);

	logic               mem_we;
	logic [IW-1:0]      mem_waddr, mem_raddr;
	logic [ENTRY_W-1:0] mem_wdata, mem_rdata;
	logic               res_valid, res_ready;
	chrt_result_t       res;
	chrt_result_t       out_q;
	logic               out_valid_q;

	chrt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	chrt_seq #(
		.CAPACITY(CAPACITY)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.key_point  (key_point),
		.site_ident (site_ident),
		.entry_index(entry_index),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_q.status;
	assign found_index = out_q.index;
	assign found_point = out_q.point;
	assign found_site  = out_q.site;
	assign entry_total = out_q.total;

`ifndef ASSERT_OFF
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while an operation is in flight");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_FULL) |-> (entry_total == 9'(CAPACITY % 512)))
		else $error("full reported below capacity");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_EMPTY) |-> (entry_total == 9'd0))
		else $error("empty reported with stored entries");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ST_FULL || status == ST_EMPTY || status == ST_RANGE))
		|-> (found_index == 8'd0 && found_point == 64'd0 && found_site == 64'd0))
		else $error("error result carries entry data");
`endif

endmodule

FILE: tb/sv/chrt_ring_checker.sv
`timescale 1ns / 1ps
// Scoreboard for consistent_hash_ring_table: watches both handshakes, keeps a shadow
// of the sorted ring table and compares every result transfer. Depends on chrt_pkg.
module chrt_ring_checker #(
	parameter int CAPACITY = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  op,
	input  logic [63:0] key_point,
	input  logic [63:0] site_ident,
	input  logic [7:0]  entry_index,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  status,
	input  logic [7:0]  found_index,
	input  logic [63:0] found_point,
	input  logic [63:0] found_site,
	input  logic [8:0]  entry_total,
	output int          fail_count,
	output int          expect_depth,
	output int          result_count
);

	import chrt_pkg::*;

	logic [POINT_W-1:0] tbl_point [CAPACITY];
	logic [SITE_W-1:0]  tbl_site  [CAPACITY];
	int                 tbl_used;
	chrt_result_t       pending_results [$];

	initial begin
		tbl_used     = 0;
		fail_count   = 0;
		expect_depth = 0;
		result_count = 0;
	end

	// strict: first slot with point above key; otherwise first slot at or above key
	function automatic int ring_search(logic [63:0] key, bit strict);
		int lo, hi, mid;
		lo = 0;
		hi = tbl_used;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (tbl_point[mid] < key || (strict && tbl_point[mid] == key))
				lo = mid + 1;
			else
				hi = mid;
		end
		return lo;
	endfunction

	function automatic chrt_result_t ring_update(chrt_op_t code, logic [63:0] key,
			logic [63:0] site, logic [7:0] idx);
		chrt_result_t r;
		int pos, i;
		r = '0;
		r.status = ST_OK;
		case (code)
			OP_ADD: begin
				if (tbl_used >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					pos = ring_search(key, 1'b1);
					for (i = tbl_used; i > pos; i--) begin
						tbl_point[i] = tbl_point[i - 1];
						tbl_site[i]  = tbl_site[i - 1];
					end
					tbl_point[pos] = key;
					tbl_site[pos]  = site;
					tbl_used++;
					r.index = 8'(pos);
					r.point = key;
					r.site  = site;
				end
			end
			OP_DEL: begin
				if (int'(idx) >= tbl_used) begin
					r.status = ST_RANGE;
				end else begin
					r.index = idx;
					r.point = tbl_point[idx];
					r.site  = tbl_site[idx];
					for (i = int'(idx); i + 1 < tbl_used; i++) begin
						tbl_point[i] = tbl_point[i + 1];
						tbl_site[i]  = tbl_site[i + 1];
					end
					tbl_used--;
				end
			end
			OP_LOOKUP: begin
				if (tbl_used == 0) begin
					r.status = ST_EMPTY;
				end else begin
					pos = ring_search(key, 1'b0);
					if (pos >= tbl_used)
						pos = 0;	// wrap around the ring
					r.index = 8'(pos);
					r.point = tbl_point[pos];
					r.site  = tbl_site[pos];
				end
			end
			default: ;
		endcase
		r.total = 9'(tbl_used);
		return r;
	endfunction

	always @(posedge clk) begin : watch
		chrt_result_t want, got;
		if (arst_n) begin
			// input first: a result leaving now always belongs to an earlier transfer
			if (in_valid && in_ready)
				pending_results.push_back(ring_update(chrt_op_t'(op), key_point,
					site_ident, entry_index));
			if (out_valid && out_ready) begin
				got.status = chrt_status_t'(status);
				got.index  = found_index;
				got.point  = found_point;
				got.site   = found_site;
				got.total  = entry_total;
				result_count <= result_count + 1;
				if (pending_results.size() == 0) begin
					if (fail_count < 10)
						$display("%t: unexpected result status=%0d index=%0d total=%0d",
							$realtime, status, found_index, entry_total);
					fail_count <= fail_count + 1;
				end else begin
					want = pending_results.pop_front();
					if (got.status !== want.status || got.index !== want.index ||
							got.point !== want.point || got.site !== want.site ||
							got.total !== want.total) begin
						if (fail_count < 10) begin
							$display("%t: mismatch, expected status=%0d index=%0d total=%0d",
								$realtime, want.status, want.index, want.total);
							$display("    point=%h site=%h", want.point, want.site);
							$display("  actual status=%0d index=%0d total=%0d",
								got.status, got.index, got.total);
							$display("    point=%h site=%h", got.point, got.site);
						end
						fail_count <= fail_count + 1;
					end
				end
			end
			expect_depth <= pending_results.size();
		end
	end

endmodule

FILE: tb/sv/consistent_hash_ring_table_tb.sv
`timescale 1ns / 1ps
// Top of the ring table testbench: clock, reset, stimulus, receiver stalls and verdict.
// Depends on chrt_pkg, consistent_hash_ring_table and chrt_ring_checker.
module consistent_hash_ring_table_tb;
	import chrt_pkg::*;

	localparam int CAP        = 256;
	localparam int RAND_ITEMS = 1380;
	localparam int PHASE_LEN  = 345;
	localparam int QUIET_MAX  = 5000;
	localparam int TAIL       = 400;

	logic        clk;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_ready;
	logic [1:0]  op          = OP_NONE;
	logic [63:0] key_point   = '0;
	logic [63:0] site_ident  = '0;
	logic [7:0]  entry_index = '0;
	logic        out_valid;
	logic        out_ready   = 1'b0;
	logic [1:0]  status;
	logic [7:0]  found_index;
	logic [63:0] found_point;
	logic [63:0] found_site;
	logic [8:0]  entry_total;

	int fail_count, expect_depth, result_count;
	int send_idle    = 0;
	int stall_pct    = 0;
	int stored       = 0;
	int sent         = 0;
	int full_events  = 0;
	int empty_events = 0;
	int quiet        = 0;
	logic [63:0] key_pool [8];

	consistent_hash_ring_table #(.CAPACITY(CAP)) DUT (.*);

	chrt_ring_checker #(.CAPACITY(CAP)) u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= stall_pct);

	// no transfer on either side for too long means the block hung
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= QUIET_MAX) begin
				$display("%t: no transfer for %0d cycles", $realtime, quiet);
				$display("simulation failed");
				$finish;
			end
		end
	end

	// called at a clock edge; returns at the edge where the transfer happened
	task automatic issue_op(chrt_op_t code, logic [63:0] key, logic [63:0] site,
			logic [7:0] ix);
		while (send_idle != 0 && $urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		op          <= code;
		key_point   <= key;
		site_ident  <= site;
		entry_index <= ix;
		do @(posedge clk); while (!in_ready);
		sent++;
		if (code == OP_ADD && stored < CAP) begin
			stored++;
			if (stored == CAP)
				full_events++;
		end else if (code == OP_DEL && int'(ix) < stored) begin
			stored--;
			if (stored == 0)
				empty_events++;
		end
	endtask

	// checker depth is registered, so look only after the next edge
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expect_depth != 0)
			@(posedge clk);
	endtask

	function automatic logic [63:0] pick_key();
		int r;
		r = $urandom_range(99);
		if (r < 50)
			return {$urandom, $urandom};
		if (r < 75)
			return key_pool[$urandom_range(7)];
		if (r < 90)
			return 64'($urandom_range(15));
		return ~64'($urandom_range(15));
	endfunction

	initial begin : stimulus
		int n, pick, phase, directed;
		bit grow;
		logic [7:0] ix;
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (n = 2; n < 8; n++)
			key_pool[n] = {$urandom, $urandom};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table corners
		issue_op(OP_LOOKUP, '0, {$urandom, $urandom}, 8'd0);
		issue_op(OP_DEL, {$urandom, $urandom}, {$urandom, $urandom}, 8'd0);
		issue_op(OP_DEL, '1, '1, 8'hFF);
		issue_op(OP_NONE, '1, '1, 8'hFF);
		// extremes and duplicate points: equal adds land after the earlier ones
		issue_op(OP_ADD, '0, '1, 8'd0);
		issue_op(OP_ADD, '1, '0, 8'hFF);
		issue_op(OP_ADD, 64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555, 8'h55);
		issue_op(OP_ADD, 64'h8000_0000_0000_0000, 64'hAAAA_AAAA_AAAA_AAAA, 8'hAA);
		issue_op(OP_ADD, '0, 64'h0123_4567_89AB_CDEF, 8'd0);
		issue_op(OP_LOOKUP, '0, '0, 8'd0);
		issue_op(OP_LOOKUP, 64'h8000_0000_0000_0000, '0, 8'd0);
		issue_op(OP_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, '0, 8'd0);
		issue_op(OP_LOOKUP, 64'h8000_0000_0000_0001, '0, 8'd0);
		issue_op(OP_LOOKUP, '1, '0, 8'd0);
		// drop the top point so a lookup of the max key wraps to entry 0
		issue_op(OP_DEL, '0, '0, 8'd4);
		issue_op(OP_LOOKUP, '1, '1, 8'd0);
		issue_op(OP_DEL, '0, '0, 8'd4);
		issue_op(OP_DEL, '0, '0, 8'hFF);
		issue_op(OP_NONE, 64'h5A5A_5A5A_5A5A_5A5A, '0, 8'h5A);
		issue_op(OP_DEL, '1, '1, 8'd0);
		issue_op(OP_DEL, '1, '1, 8'd2);
		issue_op(OP_LOOKUP, 64'd1, '0, 8'd0);
		directed = sent;

		for (n = 0; n < RAND_ITEMS; n++) begin
			if (n % PHASE_LEN == 0) begin
				wait_drained();
				phase     = n / PHASE_LEN;
				send_idle = (phase == 1) ? 45 : (phase == 3) ? 18 : 0;
				stall_pct = (phase == 2) ? 45 : (phase == 3) ? 18 : 0;
			end
			// alternate growing and shrinking stretches so the table hits full and empty
			grow = ((n / 64) % 10) < 5;
			pick = $urandom_range(99);
			if (pick < (grow ? 85 : 5)) begin
				issue_op(OP_ADD, pick_key(), {$urandom, $urandom}, 8'($urandom));
			end else if (pick < (grow ? 90 : 85)) begin
				if (stored > 0 && $urandom_range(99) < 85)
					ix = 8'($urandom_range(stored - 1));
				else
					ix = 8'($urandom);
				issue_op(OP_DEL, {$urandom, $urandom}, {$urandom, $urandom}, ix);
			end else if (pick < 98) begin
				issue_op(OP_LOOKUP, pick_key(), {$urandom, $urandom}, 8'($urandom));
			end else begin
				issue_op(OP_NONE, {$urandom, $urandom}, {$urandom, $urandom}, 8'($urandom));
			end
		end

		wait_drained();
		repeat (TAIL) @(posedge clk);
		$display("%0d ring operations sent (%0d directed), %0d results compared",
			sent, directed, result_count);
		$display("table reached capacity %0d times and was emptied %0d times",
			full_events, empty_events);
		if (fail_count == 0 && expect_depth == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
